// ===== hdl/mt_pkg.sv =====
// Package for the Mersenne Twister generator: command codes, state machine
// states, command and status bundles, and the twist and temper functions.
// No dependencies.
package mt_pkg;

  localparam int unsigned N_WORDS = 624;
  localparam int unsigned M_OFF   = 397;
  localparam int unsigned IDX_W   = 10;
  localparam logic [31:0] TWIST_CONST  = 32'h9908b0df;
  localparam logic [31:0] HI_BIT       = 32'h80000000;
  localparam logic [31:0] LO_BITS      = 32'h7fffffff;
  localparam logic [31:0] INIT_MULT    = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [IDX_W-1:0] IDX_FULL     = 10'd624;
  localparam logic [IDX_W-1:0] IDX_UNSEEDED = 10'd625;

  typedef enum logic [1:0] {
    CMD_DRAW32  = 2'd0,
    CMD_DRAW64  = 2'd1,
    CMD_RANGED  = 2'd2,
    CMD_RESEED  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_TW_RD0,
    ST_TW_RD1,
    ST_TW_RD2,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_WAIT,
    ST_DRAW_TEMP,
    ST_MOD_RUN,
    ST_FINISH,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;     // capture the input transaction
    logic seed_start;    // write word 0 with the seed source
    logic seed_default;  // seed source is the default seed
    logic seed_mul;      // register the Knuth product for the next word
    logic seed_write;    // write the next seed word, advance counter
    logic tw_rd_cur;     // read word k
    logic tw_rd_nxt;     // read word k+1
    logic tw_rd_far;     // read word k+397
    logic tw_write;      // write twisted word k, advance counter
    logic tw_clear;      // counter to zero
    logic draw_read;     // read word at read index
    logic draw_temper;   // temper the read word and append it
    logic mod_start;     // load the remainder unit
    logic mod_step;      // one remainder step
    logic finish;        // form the result
  } mt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;
    logic idx_full;      // read index at 624
    logic idx_unseeded;  // read index above 624
    logic cnt_last;      // counter at the last word
    logic bad_range;     // lower bound above upper bound
    logic span_zero;     // full 64-bit span
    logic span_small;    // span below 2^31
    logic mod_done;      // remainder unit finished
  } mt_stat_t;

  function automatic logic [31:0] twist_one(input logic [31:0] cur,
                                            input logic [31:0] nxt,
                                            input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] r;
    y = (cur & HI_BIT) | (nxt & LO_BITS);
    r = far ^ (y >> 1);
    if (y[0]) begin
      r = r ^ TWIST_CONST;
    end
    return r;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== hdl/mt_stream_if.sv =====
// Valid/ready channel interface carrying a packed payload.
// No dependencies.
interface mt_stream_if #(
  parameter int unsigned WIDTH = 32
) (
  input logic clk
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/mt_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module mt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/mt_datapath.sv =====
// Datapath of the Mersenne Twister: state memory, read index, seed and twist
// counter, tempering, 64-bit bit-serial remainder unit and result register.
// Depends on mt_pkg and mt_ram.
module mt_datapath (
  input  logic           clk,
  input  logic           rst,
  input  mt_pkg::mt_cmd_t cmd,
  output mt_pkg::mt_stat_t stat,
  input  logic [1:0]     in_cmd,
  input  logic [31:0]    in_seed,
  input  logic [63:0]    in_low,
  input  logic [63:0]    in_high,
  output logic [63:0]    res_value,
  output logic           res_error
);
  import mt_pkg::*;

  localparam int unsigned AW = $clog2(N_WORDS);

  // Captured transaction.
  cmd_t        item_cmd;
  logic [31:0] item_seed;
  logic [63:0] item_low;
  logic [63:0] span;
  logic        bad_range;

  logic [IDX_W-1:0] read_index;
  logic [AW-1:0]    cnt;
  logic [31:0]      prev_word;
  logic [31:0]      prod;
  logic [31:0]      w_cur;
  logic [31:0]      w_nxt;
  logic [63:0]      draw;

  // Remainder unit.
  logic [63:0] rem;
  logic [63:0] quo_src;
  logic [6:0]  mod_cnt;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [31:0]   ram_wdata;
  logic [31:0]   ram_rdata;

  logic [AW-1:0] cnt_nxt_addr;
  logic [AW-1:0] cnt_far_addr;
  logic [10:0]   far_sum;
  logic [64:0]   rem_shift;

  mt_ram #(.WIDTH(32), .DEPTH(N_WORDS)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // Neighbor addresses with wrap at the memory end.
  assign cnt_nxt_addr = (cnt == AW'(N_WORDS - 1)) ? '0 : cnt + AW'(1);
  assign far_sum = {1'b0, cnt} + 11'(M_OFF);
  assign cnt_far_addr = (far_sum >= 11'(N_WORDS)) ? AW'(far_sum - 11'(N_WORDS))
                                                  : AW'(far_sum);

  // Memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cnt;
    ram_wdata = prod;
    if (cmd.seed_start) begin
      ram_we    = 1'b1;
      ram_addr  = '0;
      ram_wdata = cmd.seed_default ? DEFAULT_SEED : item_seed;
    end else if (cmd.seed_write) begin
      ram_we    = 1'b1;
      ram_addr  = cnt;
      ram_wdata = prod;
    end else if (cmd.tw_write) begin
      ram_we    = 1'b1;
      ram_addr  = cnt;
      ram_wdata = twist_one(w_cur, w_nxt, ram_rdata);
    end else if (cmd.tw_rd_nxt) begin
      ram_addr = cnt_nxt_addr;
    end else if (cmd.tw_rd_far) begin
      ram_addr = cnt_far_addr;
    end else if (cmd.draw_read) begin
      ram_addr = read_index[AW-1:0];
    end
  end

  assign rem_shift = {rem, quo_src[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index <= IDX_UNSEEDED;
    end else begin
      if (cmd.seed_start) begin
        read_index <= IDX_FULL;
      end else if (cmd.tw_clear && !cmd.seed_start) begin
        read_index <= read_index;
      end
      if (cmd.tw_write && cnt == AW'(N_WORDS - 1)) begin
        read_index <= '0;
      end
      if (cmd.draw_temper) begin
        read_index <= read_index + IDX_W'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd  <= cmd_t'(in_cmd);
      item_seed <= in_seed;
      item_low  <= in_low;
      span      <= in_high - in_low + 64'd1;
      bad_range <= $signed(in_low) > $signed(in_high);
      draw      <= '0;
    end
    if (cmd.seed_start) begin
      prev_word <= cmd.seed_default ? DEFAULT_SEED : item_seed;
    end
    if (cmd.seed_mul) begin
      prod <= INIT_MULT * (prev_word ^ (prev_word >> 30)) + 32'(cnt);
    end
    if (cmd.seed_write) begin
      prev_word <= prod;
    end
    // Seed and twist counter; a clear wins over the last seed write.
    priority if (cmd.tw_clear) begin
      cnt <= '0;
    end else if (cmd.seed_start) begin
      cnt <= AW'(1);
    end else if (cmd.seed_write) begin
      cnt <= cnt + AW'(1);
    end else if (cmd.tw_write) begin
      cnt <= cnt_nxt_addr;
    end else begin
      cnt <= cnt;
    end
    if (cmd.tw_rd_nxt) begin
      w_cur <= ram_rdata;
    end
    if (cmd.tw_rd_far) begin
      w_nxt <= ram_rdata;
    end
    if (cmd.draw_temper) begin
      draw <= {draw[31:0], temper(ram_rdata)};
    end
    // Restoring remainder, one dividend bit per step.
    if (cmd.mod_start) begin
      rem     <= '0;
      quo_src <= draw;
      mod_cnt <= '0;
    end else if (cmd.mod_step) begin
      if (rem_shift >= {1'b0, span}) begin
        rem <= 64'(rem_shift - {1'b0, span});
      end else begin
        rem <= rem_shift[63:0];
      end
      quo_src <= quo_src << 1;
      mod_cnt <= mod_cnt + 7'd1;
    end
    if (cmd.finish) begin
      res_error <= 1'b0;
      unique case (item_cmd)
        CMD_DRAW32, CMD_DRAW64: res_value <= draw;
        CMD_RANGED: begin
          if (bad_range) begin
            res_value <= '0;
            res_error <= 1'b1;
          end else if (span == '0) begin
            res_value <= item_low + draw;
          end else begin
            res_value <= item_low + rem;
          end
        end
        CMD_RESEED: res_value <= '0;
        default: res_value <= '0;
      endcase
    end
  end

  assign stat.cmd          = item_cmd;
  assign stat.idx_full     = (read_index == IDX_FULL);
  assign stat.idx_unseeded = (read_index > IDX_FULL);
  assign stat.cnt_last     = (cnt == AW'(N_WORDS - 1));
  assign stat.bad_range    = bad_range;
  assign stat.span_zero    = (span == '0);
  assign stat.span_small   = (span < 64'h80000000);
  assign stat.mod_done     = (mod_cnt == 7'd64);

  // The read index never runs past the unseeded mark.
  assert property (@(posedge clk) disable iff (rst) read_index <= IDX_UNSEEDED)
    else $error("read index out of range");
  // A draw never reads before the memory is seeded and twisted.
  assert property (@(posedge clk) disable iff (rst)
    cmd.draw_read |-> read_index < IDX_FULL)
    else $error("draw from exhausted state");
  // A seed write always follows its product.
  assert property (@(posedge clk) disable iff (rst) cmd.seed_write |-> $past(cmd.seed_mul))
    else $error("seed write without product");
endmodule

// ===== hdl/mt_ctrl.sv =====
// Controller state machine of the Mersenne Twister: sequences seeding,
// twisting, word draws, remainder steps and the output handshake.
// Depends on mt_pkg.
module mt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mt_pkg::mt_cmd_t  cmd,
  input  mt_pkg::mt_stat_t stat
);
  import mt_pkg::*;

  state_t state, state_next;
  logic [1:0] words_left, words_left_next;
  logic       use_mod, use_mod_next;
  logic       out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      words_left <= '0;
      use_mod    <= 1'b0;
      out_full   <= 1'b0;
    end else begin
      state      <= state_next;
      words_left <= words_left_next;
      use_mod    <= use_mod_next;
      out_full   <= out_full_next;
    end
  end

  // The result register parts the two sides, so a held result does not block input.
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_full;

  always_comb begin
    state_next      = state;
    words_left_next = words_left;
    use_mod_next    = use_mod;
    out_full_next   = out_full && !out_ready;
    cmd             = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        use_mod_next = 1'b0;
        unique case (stat.cmd)
          CMD_RESEED: begin
            cmd.seed_start = 1'b1;
            state_next     = ST_SEED_MUL;
          end
          CMD_DRAW32: begin
            words_left_next = 2'd1;
            state_next      = ST_DRAW_RD;
          end
          CMD_DRAW64: begin
            words_left_next = 2'd2;
            state_next      = ST_DRAW_RD;
          end
          CMD_RANGED: begin
            if (stat.bad_range) begin
              state_next = ST_FINISH;
            end else begin
              // A full 64-bit span takes a 64-bit draw with no reduction.
              words_left_next = (stat.span_small && !stat.span_zero) ? 2'd1 : 2'd2;
              use_mod_next    = !stat.span_zero;
              state_next      = ST_DRAW_RD;
            end
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd.seed_write = 1'b1;
        if (stat.cnt_last) begin
          state_next = (stat.cmd == CMD_RESEED) ? ST_FINISH : ST_DRAW_RD;
          if (stat.cmd != CMD_RESEED) begin
            cmd.tw_clear = 1'b1;
            state_next   = ST_TW_RD0;
          end
        end else begin
          state_next = ST_SEED_MUL;
        end
      end
      ST_TW_RD0: begin
        cmd.tw_rd_cur = 1'b1;
        state_next    = ST_TW_RD1;
      end
      ST_TW_RD1: begin
        cmd.tw_rd_nxt = 1'b1;
        state_next    = ST_TW_RD2;
      end
      ST_TW_RD2: begin
        cmd.tw_rd_far = 1'b1;
        state_next    = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd.tw_write = 1'b1;
        state_next   = stat.cnt_last ? ST_DRAW_RD : ST_TW_RD0;
      end
      ST_DRAW_RD: begin
        if (stat.idx_unseeded) begin
          cmd.seed_start   = 1'b1;
          cmd.seed_default = 1'b1;
          state_next       = ST_SEED_MUL;
        end else if (stat.idx_full) begin
          cmd.tw_clear = 1'b1;
          state_next   = ST_TW_RD0;
        end else begin
          cmd.draw_read = 1'b1;
          state_next    = ST_DRAW_WAIT;
        end
      end
      ST_DRAW_WAIT: begin
        // Keep the read address so the word is still on the read port.
        cmd.draw_read = 1'b1;
        state_next    = ST_DRAW_TEMP;
      end
      ST_DRAW_TEMP: begin
        cmd.draw_temper = 1'b1;
        words_left_next = words_left - 2'd1;
        if (words_left == 2'd1) begin
          if (use_mod) begin
            state_next = ST_MOD_RUN;
          end else begin
            state_next = ST_FINISH;
          end
        end else begin
          state_next = ST_DRAW_RD;
        end
      end
      ST_MOD_RUN: begin
        cmd.mod_start = 1'b1;
        state_next    = ST_OUT;
        use_mod_next  = 1'b0;
      end
      ST_OUT: begin
        if (stat.mod_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_full) begin
          cmd.finish    = 1'b1;
          out_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A result stays offered until it is taken.
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped before accept");
  // The result register is only written when empty.
  assert property (@(posedge clk) disable iff (rst) cmd.finish |-> !out_full)
    else $error("result overwritten");
  // Each accepted transaction leaves idle.
  assert property (@(posedge clk) disable iff (rst) cmd.load_item |=> state == ST_DECODE)
    else $error("accept without decode");
endmodule

// ===== hdl/mersenne_twister_generator.sv =====
// Top level of the MT19937 generator: channels, controller and datapath.
// Depends on mt_pkg, mt_stream_if, mt_ctrl and mt_datapath.
//
// Channel  Direction  Payload (LSB first)
// in_ch    sink       cmd[1:0], seed_value[33:2], range_low[97:34], range_high[161:98]
// out_ch   source     value[63:0], range_error[64]
//
// A 32-bit draw reads one word and a 64-bit draw two; a ranged draw
// whose span needs reduction also runs the bit-serial 64-bit divider.
// A reseed forms and writes each of the 624 words in turn; the twist pass
// every 624 words does three reads and a write per word on the single memory port.
// Reset clears the control state and marks the generator unseeded.
// One transaction is in work at a time; the next input is taken while a result
// is held, and its own result waits until the held one is accepted.
module mersenne_twister_generator (
  input logic        clk,
  input logic        rst,
  mt_stream_if.sink   in_ch,
  mt_stream_if.source out_ch
);
  import mt_pkg::*;

  mt_cmd_t     cmd;
  mt_stat_t    stat;
  logic [63:0] res_value;
  logic        res_error;

  mt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mt_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_cmd   (in_ch.data[1:0]),
    .in_seed  (in_ch.data[33:2]),
    .in_low   (in_ch.data[97:34]),
    .in_high  (in_ch.data[161:98]),
    .res_value(res_value),
    .res_error(res_error)
  );

  assign out_ch.data = {res_error, res_value};
endmodule

// ===== tb/tb.sv =====
// Testbench for the Mersenne Twister generator: directed and random commands,
// scored against an in-bench MT19937 predictor.
// Depends on mt_pkg, mt_stream_if and mersenne_twister_generator.
`timescale 1ns / 1ps

module tb;
  import mt_pkg::*;

  localparam int IN_W  = 162;
  localparam int OUT_W = 65;

  typedef struct packed {
    logic        range_error;
    logic [63:0] value;
  } mt_result_t;

  int errors = 0;

  // Print one mismatch line and count it.
  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Predicts each transaction from its own copy of the generator state.
  class mt_scoreboard;
    logic [31:0] words[N_WORDS];
    int unsigned widx;
    mt_result_t  pending[$];

    function new();
      widx = N_WORDS + 1;
    endfunction

    function void seed_words(input logic [31:0] s);
      words[0] = s;
      for (int i = 1; i < N_WORDS; i++)
        words[i] = INIT_MULT * (words[i-1] ^ (words[i-1] >> 30)) + 32'(i);
      widx = N_WORDS;
    endfunction

    function logic [31:0] next_word();
      logic [31:0] y;
      logic [31:0] r;
      if (widx >= N_WORDS) begin
        if (widx != N_WORDS) seed_words(32'd5489);
        for (int k = 0; k < N_WORDS; k++) begin
          y = (words[k] & 32'h80000000) | (words[(k+1) % N_WORDS] & 32'h7fffffff);
          r = words[(k + 397) % N_WORDS] ^ (y >> 1);
          if (y[0]) r = r ^ 32'h9908b0df;
          words[k] = r;
        end
        widx = 0;
      end
      y = words[widx];
      widx++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
    endfunction

    function logic [63:0] next_pair();
      logic [31:0] hi;
      hi = next_word();
      return {hi, next_word()};
    endfunction

    // Note one accepted input transaction.
    function void note_command(input cmd_t cmd, input logic [31:0] s,
                               input logic [63:0] lo, input logic [63:0] hi);
      mt_result_t r;
      logic [63:0] span;
      r = '0;
      case (cmd)
        CMD_DRAW32: r.value = {32'd0, next_word()};
        CMD_DRAW64: r.value = next_pair();
        CMD_RANGED: begin
          if ($signed(lo) > $signed(hi)) begin
            r.range_error = 1'b1;
          end else begin
            span = hi - lo + 64'd1;
            if (span == 0) r.value = lo + next_pair();
            else if (span < 64'h80000000) r.value = lo + 64'(next_word() % span[31:0]);
            else r.value = lo + next_pair() % span;
          end
        end
        default: seed_words(s);
      endcase
      pending.push_back(r);
    endfunction

    // Check one accepted result transaction.
    task check_result(input mt_result_t got);
      mt_result_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result value=%h", got.value));
        return;
      end
      exp = pending.pop_front();
      if (got.value !== exp.value)
        report($sformatf("value %h, expected %h", got.value, exp.value));
      if (got.range_error !== exp.range_error)
        report($sformatf("range_error %b, expected %b", got.range_error,
                         exp.range_error));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  mt_stream_if #(.WIDTH(IN_W))  in_ch (clk);
  mt_stream_if #(.WIDTH(OUT_W)) out_ch (clk);

  mersenne_twister_generator dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  mt_scoreboard sb = new();
  bit long_hold = 1'b0;
  bit quiet_out = 1'b0;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: stall pattern with quiet stretches and one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_out ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Score every accepted result transaction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
  end

  int burst_left = 0;

  // Offer one command and hold it until accepted; gaps come between bursts.
  task automatic send(input cmd_t cmd, input logic [31:0] s,
                      input logic [63:0] lo, input logic [63:0] hi);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= {hi, lo, s, cmd};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_command(cmd, s, lo, hi);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Long receiver hold-off while the sender keeps offering.
  task automatic hold_receiver();
    long_hold = 1'b1;
    repeat (400) @(posedge clk);
    long_hold = 1'b0;
  endtask

  // Random ranged bounds: small, wide, full or reversed spans.
  task automatic send_ranged();
    logic [63:0] lo;
    logic [63:0] hi;
    int kind;
    kind = $urandom_range(0, 9);
    lo = rand64();
    if (kind < 5) lo = {{32{lo[31]}}, lo[31:0]};
    case (kind)
      0, 1, 2: hi = lo + 64'($urandom_range(0, 1000));
      3:       hi = lo + {32'd0, $urandom()} ;
      4:       hi = lo + 64'h7fffffff;
      5:       hi = lo - 64'd1 - 64'($urandom_range(0, 50));
      6:       begin lo = 64'h8000000000000000; hi = 64'h7fffffffffffffff; end
      default: hi = rand64();
    endcase
    send(CMD_RANGED, $urandom(), lo, hi);
  endtask

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: draw before seeding, then extremes of every command.
    send(CMD_DRAW32, 32'd0, 64'd0, 64'd0);
    send(CMD_DRAW64, 32'd0, 64'd0, 64'd0);
    send(CMD_RANGED, 32'd0, 64'd5, 64'd5);
    send(CMD_RANGED, 32'd0, 64'd6, 64'd5);
    send(CMD_RANGED, 32'd0, 64'h8000000000000000, 64'h7fffffffffffffff);
    send(CMD_RANGED, 32'd0, 64'hffffffffffffffff, 64'h000000007ffffffd);
    send(CMD_RANGED, 32'd0, 64'd0, 64'h000000007ffffffe);
    send(CMD_RANGED, 32'd0, 64'd0, 64'h000000007fffffff);
    send(CMD_RANGED, 32'd0, 64'h7fffffffffffffff, 64'h8000000000000000);
    send(CMD_RANGED, 32'd0, 64'h8000000000000000, 64'h8000000000000001);
    send(CMD_RESEED, 32'hffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff);
    send(CMD_DRAW64, 32'd0, 64'd0, 64'd0);
    send(CMD_RESEED, 32'd0, 64'd0, 64'd0);
    send(CMD_DRAW32, 32'd0, 64'd0, 64'd0);
    send(CMD_RESEED, 32'd5489, 64'd0, 64'd0);
    send(CMD_DRAW32, 32'd0, 64'd0, 64'd0);

    // Pressure: receiver holds off while commands keep coming.
    fork
      hold_receiver();
      for (int i = 0; i < 6; i++) send(CMD_DRAW32, 32'd0, 64'd0, 64'd0);
    join

    // Random: mostly draws so the twist pass runs many times.
    for (int i = 0; i < 935; i++) begin
      quiet_out = (i / 100) % 3 == 1;
      if (i % 150 == 0) burst_left = 0;
      r = $urandom_range(0, 99);
      if (r < 35) send(CMD_DRAW32, $urandom(), rand64(), rand64());
      else if (r < 60) send(CMD_DRAW64, $urandom(), rand64(), rand64());
      else if (r < 98) send_ranged();
      else send(CMD_RESEED, $urandom(), rand64(), rand64());
    end
    in_ch.valid <= 1'b0;
    quiet_out = 1'b1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // Run limit: generous against slowest reseeds, twists and divider stalls.
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
